### rtl/cpsb_pkg.sv
// Shared types, constants and the element map for the control panel scan unit.
// Used by every module under rtl/; depends on nothing.
package cpsb_pkg;

   // Bank count for the per-button toggle stores, and the width of a bank index.
   localparam int BANK_COUNT = 4;
   localparam int BANK_IDX_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 11;
   localparam int BANK_W    = 2;
   localparam int ELEMENT_W = 4;
   localparam int TOGGLE_W  = 7;
   localparam int STEP_W    = 3;
   localparam int KIND_W    = 2;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_BANK   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_Q10      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_BELOW   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_ABOVE = 2'd3;

   localparam logic [BANK_W-1:0]   ACTIVE_BANK_RESET   = 2'd0;
   localparam logic [GAIN_W-1:0]   GAIN_Q10_RESET      = 11'd1055;
   localparam logic [SAMPLE_W-1:0] PRESS_BELOW_RESET   = 16'd200;
   localparam logic [SAMPLE_W-1:0] RELEASE_ABOVE_RESET = 16'd60000;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

   // Toggle output levels and three-state codes.
   localparam logic [TOGGLE_W-1:0] TOGGLE_OFF = 7'd0;
   localparam logic [TOGGLE_W-1:0] TOGGLE_MID = 7'd63;
   localparam logic [TOGGLE_W-1:0] TOGGLE_ON  = 7'd127;

   localparam logic [1:0] THREE_OFF = 2'd0;
   localparam logic [1:0] THREE_MID = 2'd1;
   localparam logic [1:0] THREE_ON  = 2'd2;

   // Offset from the scan element of a button row to its button element.
   localparam logic [ELEMENT_W-1:0] BUTTON_ELEMENT_OFFSET = 4'd4;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_first;
      logic [SAMPLE_W-1:0] sample_second;
   } req_type;

   typedef struct packed {
      logic [STEP_W-1:0]    mux_select;
      logic [KIND_W-1:0]    first_kind;
      logic [ELEMENT_W-1:0] first_element;
      logic [SAMPLE_W-1:0]  first_value;
      logic [TOGGLE_W-1:0]  first_toggle_two;
      logic [TOGGLE_W-1:0]  first_toggle_three;
      logic [KIND_W-1:0]    second_kind;
      logic [ELEMENT_W-1:0] second_element;
      logic [SAMPLE_W-1:0]  second_value;
      logic [TOGGLE_W-1:0]  second_toggle_two;
      logic [TOGGLE_W-1:0]  second_toggle_three;
   } rsp_type;

   // Button thresholds handed to the button units.
   typedef struct packed {
      logic [SAMPLE_W-1:0] press_below;
      logic [SAMPLE_W-1:0] release_above;
   } thresh_type;

   // What a button unit reports for one sample.
   typedef struct packed {
      logic                 hit;
      logic [KIND_W-1:0]    kind;
      logic [SAMPLE_W-1:0]  value;
      logic [TOGGLE_W-1:0]  toggle_two;
      logic [TOGGLE_W-1:0]  toggle_three;
   } event_type;

   // Multiplexer step to element map: entry step+8 is the first converter,
   // entry step the second.
   function automatic logic [ELEMENT_W-1:0] step_element(input logic [3:0] idx);
      logic [ELEMENT_W-1:0] elem;
      unique case (idx)
         4'd0:  elem = 4'd0;
         4'd1:  elem = 4'd1;
         4'd2:  elem = 4'd4;
         4'd3:  elem = 4'd5;
         4'd4:  elem = 4'd8;
         4'd5:  elem = 4'd9;
         4'd6:  elem = 4'd12;
         4'd7:  elem = 4'd13;
         4'd8:  elem = 4'd2;
         4'd9:  elem = 4'd3;
         4'd10: elem = 4'd6;
         4'd11: elem = 4'd7;
         4'd12: elem = 4'd10;
         4'd13: elem = 4'd11;
         4'd14: elem = 4'd14;
         default: elem = 4'd15;
      endcase
      return elem;
   endfunction

   function automatic logic [TOGGLE_W-1:0] three_level(input logic [1:0] code);
      logic [TOGGLE_W-1:0] lvl;
      case (code)
         THREE_OFF: lvl = TOGGLE_OFF;
         THREE_MID: lvl = TOGGLE_MID;
         default:   lvl = TOGGLE_ON;
      endcase
      return lvl;
   endfunction

endpackage

### rtl/cpsb_scale.sv
// Q10 gain scaling of one raw sample: truncate, saturate at full scale.
// Depends on cpsb_pkg.
module cpsb_scale (
   input  logic [cpsb_pkg::SAMPLE_W-1:0] raw,
   input  logic [cpsb_pkg::GAIN_W-1:0]   gain_q10,
   output logic [cpsb_pkg::SAMPLE_W-1:0] scaled
);

   localparam int PROD_W = cpsb_pkg::SAMPLE_W + cpsb_pkg::GAIN_W;

   logic [PROD_W-1:0]             product;
   logic [PROD_W-10-1:0]          shifted;

   assign product = {{cpsb_pkg::GAIN_W{1'b0}}, raw} * {{cpsb_pkg::SAMPLE_W{1'b0}}, gain_q10};
   // drop the Q10 fraction
   assign shifted = product[PROD_W-1:10];
   assign scaled  = (shifted[PROD_W-10-1:cpsb_pkg::SAMPLE_W] != '0)
                    ? {cpsb_pkg::SAMPLE_W{1'b1}} : shifted[cpsb_pkg::SAMPLE_W-1:0];

endmodule

### rtl/cpsb_button.sv
// Two buttons scanned by one converter: held state, press/release edges and
// per-bank two-state and three-state toggles. Depends on cpsb_pkg.
module cpsb_button (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               update,
   input  logic                               sel,
   input  logic [cpsb_pkg::BANK_IDX_W-1:0]    bank,
   input  logic [cpsb_pkg::SAMPLE_W-1:0]      value,
   input  cpsb_pkg::thresh_type               thresh,
   output cpsb_pkg::event_type                evt
);

   logic [1:0]                                          held_ff, held_in;
   logic [1:0][cpsb_pkg::BANK_COUNT-1:0]                two_ff, two_in;
   logic [1:0][cpsb_pkg::BANK_COUNT-1:0][1:0]           three_ff, three_in;

   logic       released, pressed, level, edge_seen;
   logic       two_cur, two_nxt;
   logic [1:0] three_cur, three_nxt;

   always_comb begin
      // release test first, then press
      released  = value > thresh.release_above;
      pressed   = !released && (value < thresh.press_below);
      level     = pressed;
      edge_seen = (released || pressed) && (level != held_ff[sel]);

      two_cur   = two_ff[sel][bank];
      three_cur = three_ff[sel][bank];
      two_nxt   = ~two_cur;
      case (three_cur)
         cpsb_pkg::THREE_OFF: three_nxt = cpsb_pkg::THREE_MID;
         cpsb_pkg::THREE_MID: three_nxt = cpsb_pkg::THREE_ON;
         default:             three_nxt = cpsb_pkg::THREE_OFF;
      endcase

      evt = '0;
      if (edge_seen) begin
         evt.hit = 1'b1;
         if (pressed) begin
            evt.kind         = cpsb_pkg::KIND_PRESS;
            evt.value        = cpsb_pkg::SAMPLE_W'(cpsb_pkg::TOGGLE_ON);
            evt.toggle_two   = two_nxt ? cpsb_pkg::TOGGLE_ON : cpsb_pkg::TOGGLE_OFF;
            evt.toggle_three = cpsb_pkg::three_level(three_nxt);
         end else begin
            evt.kind         = cpsb_pkg::KIND_RELEASE;
            evt.value        = '0;
            evt.toggle_two   = two_cur ? cpsb_pkg::TOGGLE_ON : cpsb_pkg::TOGGLE_OFF;
            evt.toggle_three = cpsb_pkg::three_level(three_cur);
         end
      end

      held_in  = held_ff;
      two_in   = two_ff;
      three_in = three_ff;
      if (update && edge_seen) begin
         held_in[sel] = level;
         if (pressed) begin
            two_in[sel][bank]   = two_nxt;
            three_in[sel][bank] = three_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         two_ff   <= '0;
         three_ff <= '0;
      end else begin
         held_ff  <= held_in;
         two_ff   <= two_in;
         three_ff <= three_in;
      end
   end

endmodule

### rtl/control_panel_scan_and_button_toggle_unit.sv
// Top level of the control panel scan unit: input register, scaling, button
// units, result register. Depends on cpsb_pkg, cpsb_scale, cpsb_button.
//
// Usage:
//   req channel: one transaction per finished pair of conversions taken at
//   the current multiplexer step (req_valid/req_stall/req_payload).
//   rsp channel: exactly one result transaction per request, carrying the
//   next multiplexer step in mux_select plus one report per converter.
//   csr port: write csr_data to register csr_index while csr_write is high;
//   0 active bank, 1 gain (Q10), 2 press threshold, 3 release threshold.
//   Write only while no transaction is in flight.
// Pipeline: the accepting edge loads the input register; the result register is loaded
// from it once the result register is empty or being taken, and rsp_valid rises with it.
// Throughput: one transaction per cycle while no result is stalled; the scaling
// multiplier and the button compare/toggle logic sit in one stage between the two registers.
// Reset: step counter to 0, all buttons released, all toggles to 0,
// registers to their defaults; no result pending.
// Stall: while rsp_stall holds a result, the stage behind it keeps its
// transaction and req_stall rises once that stage is also full.
module control_panel_scan_and_button_toggle_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cpsb_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cpsb_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write,
   input  logic [cpsb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cpsb_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Configuration registers.
   logic [cpsb_pkg::BANK_W-1:0]   active_bank_ff, active_bank_in;
   logic [cpsb_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   logic [cpsb_pkg::SAMPLE_W-1:0] press_below_ff, press_below_in;
   logic [cpsb_pkg::SAMPLE_W-1:0] release_above_ff, release_above_in;

   // Pipeline registers.
   logic                          stage_valid_ff, stage_valid_in;
   cpsb_pkg::req_type             stage_ff, stage_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   cpsb_pkg::rsp_type             rsp_ff, rsp_in;
   logic [cpsb_pkg::STEP_W-1:0]   mux_step_ff, mux_step_in;

   logic                          advance, fire, req_take, button_step;
   logic [cpsb_pkg::STEP_W-1:0]   next_step;
   logic [cpsb_pkg::BANK_IDX_W-1:0] bank_eff;
   logic [cpsb_pkg::ELEMENT_W-1:0]  elem_first, elem_second;
   logic [cpsb_pkg::SAMPLE_W-1:0]   scaled_first, scaled_second;
   cpsb_pkg::thresh_type          thresh;
   cpsb_pkg::event_type           evt_first, evt_second;

   // Result register frees up when empty or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = stage_valid_ff && advance;
   assign req_stall = stage_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign thresh.press_below   = press_below_ff;
   assign thresh.release_above = release_above_ff;

   // Clamp an out-of-range bank to the last one.
   assign bank_eff = ({3'b000, active_bank_ff} >= 5'(cpsb_pkg::BANK_COUNT))
                     ? cpsb_pkg::BANK_IDX_W'(cpsb_pkg::BANK_COUNT - 1)
                     : cpsb_pkg::BANK_IDX_W'(active_bank_ff);

   assign elem_first  = cpsb_pkg::step_element({1'b1, mux_step_ff});
   assign elem_second = cpsb_pkg::step_element({1'b0, mux_step_ff});
   assign next_step   = mux_step_ff + cpsb_pkg::STEP_W'(1);
   // steps 6 and 7 scan the button rows
   assign button_step = mux_step_ff[2] && mux_step_ff[1];

   cpsb_scale u_scale_first (
      .raw      (stage_ff.sample_first),
      .gain_q10 (gain_ff),
      .scaled   (scaled_first)
   );

   cpsb_scale u_scale_second (
      .raw      (stage_ff.sample_second),
      .gain_q10 (gain_ff),
      .scaled   (scaled_second)
   );

   // First converter sees buttons 10 and 11, second sees 8 and 9.
   cpsb_button u_button_first (
      .clock  (clock),
      .reset  (reset),
      .update (fire && button_step),
      .sel    (mux_step_ff[0]),
      .bank   (bank_eff),
      .value  (scaled_first),
      .thresh (thresh),
      .evt    (evt_first)
   );

   cpsb_button u_button_second (
      .clock  (clock),
      .reset  (reset),
      .update (fire && button_step),
      .sel    (mux_step_ff[0]),
      .bank   (bank_eff),
      .value  (scaled_second),
      .thresh (thresh),
      .evt    (evt_second)
   );

   always_comb begin
      // Configuration writes.
      active_bank_in   = active_bank_ff;
      gain_in          = gain_ff;
      press_below_in   = press_below_ff;
      release_above_in = release_above_ff;
      if (csr_write) begin
         unique case (csr_index)
            cpsb_pkg::CSR_ACTIVE_BANK:   active_bank_in   = csr_data[cpsb_pkg::BANK_W-1:0];
            cpsb_pkg::CSR_GAIN_Q10:      gain_in          = csr_data[cpsb_pkg::GAIN_W-1:0];
            cpsb_pkg::CSR_PRESS_BELOW:   press_below_in   = csr_data;
            cpsb_pkg::CSR_RELEASE_ABOVE: release_above_in = csr_data;
            default:                     gain_in          = gain_ff;
         endcase
      end

      // Input register: load on accept, drop once handed on.
      stage_in       = req_take ? req_payload : stage_ff;
      stage_valid_in = req_take || (stage_valid_ff && !advance);

      mux_step_in  = fire ? next_step : mux_step_ff;

      // Build the result for the transaction in the input register.
      rsp_in            = '0;
      rsp_in.mux_select = next_step;
      if (!mux_step_ff[2]) begin
         // pots invert, faders pass through
         rsp_in.first_kind     = cpsb_pkg::KIND_SAMPLE;
         rsp_in.first_element  = elem_first;
         rsp_in.first_value    = mux_step_ff[1] ? scaled_first : ~scaled_first;
         rsp_in.second_kind    = cpsb_pkg::KIND_SAMPLE;
         rsp_in.second_element = elem_second;
         rsp_in.second_value   = mux_step_ff[1] ? scaled_second : ~scaled_second;
      end else if (button_step) begin
         rsp_in.first_kind          = evt_first.kind;
         rsp_in.first_element       = evt_first.hit
                                      ? elem_first - cpsb_pkg::BUTTON_ELEMENT_OFFSET : '0;
         rsp_in.first_value         = evt_first.value;
         rsp_in.first_toggle_two    = evt_first.toggle_two;
         rsp_in.first_toggle_three  = evt_first.toggle_three;
         rsp_in.second_kind         = evt_second.kind;
         rsp_in.second_element      = evt_second.hit
                                      ? elem_second - cpsb_pkg::BUTTON_ELEMENT_OFFSET : '0;
         rsp_in.second_value        = evt_second.value;
         rsp_in.second_toggle_two   = evt_second.toggle_two;
         rsp_in.second_toggle_three = evt_second.toggle_three;
      end
      if (!fire) begin
         rsp_in = rsp_ff;
      end
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_bank_ff   <= cpsb_pkg::ACTIVE_BANK_RESET;
         gain_ff          <= cpsb_pkg::GAIN_Q10_RESET;
         press_below_ff   <= cpsb_pkg::PRESS_BELOW_RESET;
         release_above_ff <= cpsb_pkg::RELEASE_ABOVE_RESET;
         stage_valid_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         mux_step_ff      <= '0;
      end else begin
         active_bank_ff   <= active_bank_in;
         gain_ff          <= gain_in;
         press_below_ff   <= press_below_in;
         release_above_ff <= release_above_in;
         stage_valid_ff   <= stage_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         mux_step_ff      <= mux_step_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### tb/tb_top.sv
// Self-checking bench for control_panel_scan_and_button_toggle_unit: directed scan rounds,
// then random phases under several register settings. Depends on cpsb_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
   import cpsb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TRAIL_CYCLES = 4;

   // Multiplexer step to element map: entry step+8 feeds the first converter, entry step
   // the second.
   localparam logic [ELEMENT_W-1:0] SCAN_MAP [16] = '{
      4'd0, 4'd1, 4'd4, 4'd5, 4'd8, 4'd9, 4'd12, 4'd13,
      4'd2, 4'd3, 4'd6, 4'd7, 4'd10, 4'd11, 4'd14, 4'd15};

   // What one converter contributes to a result transaction.
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ELEMENT_W-1:0] element;
      logic [SAMPLE_W-1:0]  value;
      logic [TOGGLE_W-1:0]  two;
      logic [TOGGLE_W-1:0]  three;
   } button_note;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_payload;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   control_panel_scan_and_button_toggle_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Register shadows, kept in step with every csr write.
   logic [BANK_W-1:0]   bank_cfg;
   logic [GAIN_W-1:0]   gain_cfg;
   logic [SAMPLE_W-1:0] press_cfg;
   logic [SAMPLE_W-1:0] release_cfg;

   // Shadow of the block's own state.
   logic [STEP_W-1:0] step_mirror;
   logic              held_mirror [4];
   logic              toggle_two_mirror [BANK_COUNT*4];
   logic [1:0]        toggle_three_mirror [BANK_COUNT*4];

   req_type pending_scans[$];     // sample pairs not yet presented to the block
   rsp_type expected_reports[$];  // predicted result transactions, oldest first

   int  cycle_count;
   int  mismatches;
   bit  req_taken;      // request transaction accepted at the last rising edge
   bit  calm;           // no idling on either side while set
   int  gen_step;       // step the next queued sample pair will meet

   // Scale a raw conversion by the Q10 gain, truncating and saturating at full scale.
   function automatic logic [SAMPLE_W-1:0] scaled(input logic [SAMPLE_W-1:0] raw);
      logic [26:0] prod;
      prod = (raw * gain_cfg) >> 10;
      return (prod > 27'd65535) ? 16'hFFFF : prod[SAMPLE_W-1:0];
   endfunction

   // Classify one button sample, update the held state and toggles on an edge.
   function automatic button_note button_report(input logic [ELEMENT_W-1:0] elem,
                                                input logic [SAMPLE_W-1:0] v);
      button_note n;
      logic [1:0] b;
      logic       pressed;
      logic       decided;
      int         bank;
      int         slot;
      n = '0;
      b = elem[1:0];
      decided = 1'b1;
      pressed = 1'b0;
      // Release test wins when the thresholds overlap.
      if (v > release_cfg) pressed = 1'b0;
      else if (v < press_cfg) pressed = 1'b1;
      else decided = 1'b0;
      if (!decided || pressed == held_mirror[b]) return n;
      bank = (int'(bank_cfg) >= BANK_COUNT) ? BANK_COUNT - 1 : int'(bank_cfg);
      slot = (bank * 4 + int'(b)) % (BANK_COUNT * 4);
      if (pressed) begin
         toggle_two_mirror[slot] = ~toggle_two_mirror[slot];
         case (toggle_three_mirror[slot])
            THREE_OFF: toggle_three_mirror[slot] = THREE_MID;
            THREE_MID: toggle_three_mirror[slot] = THREE_ON;
            default:   toggle_three_mirror[slot] = THREE_OFF;
         endcase
         n.kind = KIND_PRESS;
         n.value = SAMPLE_W'(TOGGLE_ON);
      end else begin
         n.kind = KIND_RELEASE;
      end
      held_mirror[b] = pressed;
      n.element = elem;
      n.two = toggle_two_mirror[slot] ? TOGGLE_ON : TOGGLE_OFF;
      case (toggle_three_mirror[slot])
         THREE_OFF: n.three = TOGGLE_OFF;
         THREE_MID: n.three = TOGGLE_MID;
         default:   n.three = TOGGLE_ON;
      endcase
      return n;
   endfunction

   // Work out the result of one scan pair and advance the shadow state.
   function automatic rsp_type predict_scan(input req_type r);
      rsp_type          o;
      button_note       n0;
      button_note       n1;
      logic [STEP_W-1:0] step;
      logic [SAMPLE_W-1:0] v0;
      logic [SAMPLE_W-1:0] v1;
      o = '0;
      step = step_mirror;
      v0 = scaled(r.sample_first);
      v1 = scaled(r.sample_second);
      step_mirror = step + 3'd1;
      o.mux_select = step_mirror;
      if (step <= 3'd3) begin
         // Pots read inverted, faders as they are.
         if (step <= 3'd1) begin
            v0 = 16'hFFFF - v0;
            v1 = 16'hFFFF - v1;
         end
         o.first_kind     = KIND_SAMPLE;
         o.first_element  = SCAN_MAP[{1'b1, step}];
         o.first_value    = v0;
         o.second_kind    = KIND_SAMPLE;
         o.second_element = SCAN_MAP[{1'b0, step}];
         o.second_value   = v1;
      end else if (step >= 3'd6) begin
         n0 = button_report(SCAN_MAP[{1'b1, step}] - BUTTON_ELEMENT_OFFSET, v0);
         n1 = button_report(SCAN_MAP[{1'b0, step}] - BUTTON_ELEMENT_OFFSET, v1);
         o.first_kind          = n0.kind;
         o.first_element       = n0.element;
         o.first_value         = n0.value;
         o.first_toggle_two    = n0.two;
         o.first_toggle_three  = n0.three;
         o.second_kind         = n1.kind;
         o.second_element      = n1.element;
         o.second_value        = n1.value;
         o.second_toggle_two   = n1.two;
         o.second_toggle_three = n1.three;
      end
      return o;
   endfunction

   // Compare one result transaction with the oldest prediction, field by field.
   task automatic check_report(input rsp_type got);
      rsp_type want;
      bit      bad;
      if (expected_reports.size() == 0) begin
         if (mismatches < 10)
            $display("[%0d] unexpected result %h", cycle_count, got);
         mismatches++;
         return;
      end
      want = expected_reports.pop_front();
      bad = (got.mux_select          !== want.mux_select)
         || (got.first_kind          !== want.first_kind)
         || (got.first_element       !== want.first_element)
         || (got.first_value         !== want.first_value)
         || (got.first_toggle_two    !== want.first_toggle_two)
         || (got.first_toggle_three  !== want.first_toggle_three)
         || (got.second_kind         !== want.second_kind)
         || (got.second_element      !== want.second_element)
         || (got.second_value        !== want.second_value)
         || (got.second_toggle_two   !== want.second_toggle_two)
         || (got.second_toggle_three !== want.second_toggle_three);
      if (bad) begin
         if (mismatches < 10)
            $display("[%0d] mismatch: expected %p actual %p", cycle_count, want, got);
         mismatches++;
      end
   endtask

   // Pick one raw conversion. Button rows mostly get clear presses and releases so that
   // edges and toggles keep happening; the rest lands anywhere, dead zone included.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input bit button_row);
      int roll;
      roll = $urandom_range(99);
      if (button_row) begin
         if (roll < 35) return SAMPLE_W'($urandom_range(150));
         if (roll < 70) return SAMPLE_W'($urandom_range(64500, 65535));
         if (roll < 80) return (roll < 75) ? 16'h0000 : 16'hFFFF;
         return SAMPLE_W'($urandom_range(65535));
      end
      if (roll < 5) return 16'h0000;
      if (roll < 10) return 16'hFFFF;
      return SAMPLE_W'($urandom_range(65535));
   endfunction

   task automatic queue_pair(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
      req_type r;
      r.sample_first = a;
      r.sample_second = b;
      pending_scans.push_back(r);
      gen_step = (gen_step + 1) % 8;
   endtask

   // Hold the sender off until every queued transaction has been accepted and every
   // prediction has been matched, so the block is idle.
   task automatic drain();
      while (pending_scans.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = val;
      case (idx)
         CSR_ACTIVE_BANK: bank_cfg    = val[BANK_W-1:0];
         CSR_GAIN_Q10:    gain_cfg    = val[GAIN_W-1:0];
         CSR_PRESS_BELOW: press_cfg   = val;
         default:         release_cfg = val;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic apply_setting(input int bank, input int gain, input int press,
                                input int rel);
      write_reg(CSR_ACTIVE_BANK, CSR_DATA_W'(bank));
      write_reg(CSR_GAIN_Q10, CSR_DATA_W'(gain));
      write_reg(CSR_PRESS_BELOW, CSR_DATA_W'(press));
      write_reg(CSR_RELEASE_ABOVE, CSR_DATA_W'(rel));
   endtask

   task automatic run_phase(input int count);
      bit btn;
      for (int i = 0; i < count; i++) begin
         btn = (gen_step >= 6);
         queue_pair(pick_sample(btn), pick_sample(btn));
      end
      drain();
   endtask

   // Clock: 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // Monitor: sample both channels at the rising edge. Check the result first, then
   // predict the accepted request; with the result register behind the input register, a result
   // can never belong to the request accepted at the same edge.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_report(rsp_payload);
         if (req_valid && !req_stall) begin
            expected_reports.push_back(predict_scan(req_payload));
            req_taken = 1'b1;
         end
      end
   end

   // Driver: advance at the falling edge. A stalled transaction holds its payload; a
   // new one is loaded only once the old one was accepted or none was offered. Each
   // side idles at random, with a chance of 28 percent, unless calm is set.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_scans.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
               req_payload <= pending_scans.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 28);
      end
   end

   // Sequence: reset, directed scan rounds under reset settings, fixed corner settings,
   // then random settings. Every phase ends with a drain, so the sender pauses until all
   // results are in and register writes only ever meet an idle block.
   initial begin
      clock = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycle_count = 0;
      mismatches = 0;
      req_taken = 1'b0;
      calm = 1'b0;
      gen_step = 0;
      bank_cfg = ACTIVE_BANK_RESET;
      gain_cfg = GAIN_Q10_RESET;
      press_cfg = PRESS_BELOW_RESET;
      release_cfg = RELEASE_ABOVE_RESET;
      step_mirror = '0;
      for (int i = 0; i < 4; i++) held_mirror[i] = 1'b0;
      for (int i = 0; i < BANK_COUNT * 4; i++) begin
         toggle_two_mirror[i] = 1'b0;
         toggle_three_mirror[i] = THREE_OFF;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Round one: pot and fader extremes, silent rows, first press of all four buttons.
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'hFFFF, 16'h0000);
      queue_pair(16'hFFFF, 16'h0000);
      queue_pair(16'h8000, 16'h7FFF);
      queue_pair(16'h1234, 16'hFFFF);
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'h0000, 16'h0000);
      // Round two: saturating scale, then no edge: still held and dead zone; one release.
      queue_pair(16'hFFFF, 16'hFFFF);
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'hFFFF, 16'hFFFF);
      queue_pair(16'h5555, 16'hAAAA);
      queue_pair(16'hAAAA, 16'h5555);
      queue_pair(16'h0000, 16'd30000);
      queue_pair(16'd30000, 16'hFFFF);
      // Round three: release reports unchanged toggles; a second press moves them on.
      queue_pair(16'h0001, 16'h0002);
      queue_pair(16'h0003, 16'h0004);
      queue_pair(16'h00C2, 16'h00C3);
      queue_pair(16'hFFFE, 16'h7FFF);
      queue_pair(16'h0F0F, 16'hF0F0);
      queue_pair(16'hFFFF, 16'h0000);
      queue_pair(16'hFFFF, 16'h0000);
      queue_pair(16'h0000, 16'h0000);
      drain();

      // Unity gain, wider thresholds, second bank.
      apply_setting(1, 1024, 1000, 64000);
      run_phase(200);
      // Largest gain, thresholds that can never fire.
      apply_setting(3, 2047, 0, 65535);
      run_phase(100);
      // Zero gain with every sample below the press threshold.
      apply_setting(2, 0, 65535, 0);
      run_phase(100);
      // Overlapping thresholds: the release test decides first.
      apply_setting(0, 1055, 40000, 20000);
      run_phase(250);

      for (int p = 0; p < 6; p++) begin
         apply_setting($urandom_range(3),
                       ($urandom_range(99) < 70) ? $urandom_range(900, 1200)
                                                 : $urandom_range(2047),
                       ($urandom_range(99) < 70) ? $urandom_range(3000)
                                                 : $urandom_range(65535),
                       ($urandom_range(99) < 70) ? $urandom_range(55000, 65535)
                                                 : $urandom_range(65535));
         calm = (p == 2);
         run_phase(200);
         calm = 1'b0;
      end

      drain();
      repeat (TRAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
